>>> sv/gda_pkg.sv
// Shared types, constants and calendar functions for the Gregorian date unit.
// Used by every stage module and by gregorian_date_arithmetic_unit_core.
package gda_pkg;

   localparam logic [13:0] YEAR_MAX           = 14'd9999;
   localparam logic [6:0]  WEEKEND_MASK_RESET = 7'd96;
   localparam logic [8:0]  DAYS_COMMON_YEAR   = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR     = 9'd366;
   localparam logic [13:0] WEEKDAY_YEAR_SHIFT = 14'd400;

   localparam logic [2:0] KIND_NEXT_DAY   = 3'd0;
   localparam logic [2:0] KIND_PREV_DAY   = 3'd1;
   localparam logic [2:0] KIND_NEXT_MONTH = 3'd2;
   localparam logic [2:0] KIND_PREV_MONTH = 3'd3;
   localparam logic [2:0] KIND_ADD_YEARS  = 3'd4;
   localparam logic [2:0] KIND_SUB_YEARS  = 3'd5;
   localparam logic [2:0] KIND_NONE       = 3'd6;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [13:0] amount;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [4:0]         day;
      logic [3:0]         month;
      logic signed [15:0] year;
   } step_type;

   typedef struct packed {
      logic        ok;
      logic        range_err;
      logic        leap;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  len;
   } clamp_type;

   typedef struct packed {
      clamp_type   date;
      logic [8:0]  doy;
      logic [14:0] wsum;
   } sum_type;

   typedef struct packed {
      logic [4:0]  res_day;
      logic [3:0]  res_month;
      logic [13:0] res_year;
      logic        input_valid;
      logic        range_error;
      logic [2:0]  weekday;
      logic [8:0]  day_of_year;
      logic [4:0]  days_to_month_end;
      logic [8:0]  days_to_year_end;
      logic        is_leap;
      logic        is_month_end;
      logic        is_weekend;
   } rsp_type;

   // floor(v / 25) by reciprocal, exact for v < 16384
   function automatic logic [9:0] div25(input logic [13:0] v);
      logic [26:0] p;
      p = 27'(v) * 27'(13'd5243);
      return p[26:17];
   endfunction

   // v % 7 by reciprocal, exact for v < 32768
   function automatic logic [2:0] mod7(input logic [14:0] v);
      logic [30:0] p;
      logic [12:0] q;
      logic [14:0] r;
      p = 31'(v) * 31'(16'd37450);
      q = p[30:18];
      r = v - 15'(q) * 15'd7;
      return r[2:0];
   endfunction

   function automatic logic leap_year(input logic [13:0] y);
      logic [9:0]  q;
      logic [13:0] r;
      q = div25(y);
      r = y - 14'(q) * 14'd25;
      return ((y[1:0] == 2'd0) && (r != 14'd0)) || ((y[3:0] == 4'd0) && (r == 14'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      unique case (m)
         4'd2:                      n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // (31 * mm) / 12 for the March-based month mm
   function automatic logic [4:0] month_offset(input logic [3:0] mm);
      logic [4:0] n;
      unique case (mm)
         4'd1:    n = 5'd2;
         4'd2:    n = 5'd5;
         4'd3:    n = 5'd7;
         4'd4:    n = 5'd10;
         4'd5:    n = 5'd12;
         4'd6:    n = 5'd15;
         4'd7:    n = 5'd18;
         4'd8:    n = 5'd20;
         4'd9:    n = 5'd23;
         4'd10:   n = 5'd25;
         4'd11:   n = 5'd28;
         4'd12:   n = 5'd31;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

>>> sv/gregorian_date_arithmetic_unit_core.sv
// Top level of the Gregorian date unit: weekend mask register and four-stage pipeline.
// Depends on gda_pkg, gda_step, gda_clamp, gda_sum and gda_facts.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    kind, day, month, year, amount
//   rsp      out        rsp_valid/rsp_ready    date and calendar facts
//   csr      in         csr_wr_en              weekend mask, 7 bits
//
// One transfer per cycle in and out while rsp_ready is high.
// Each stage holds one item; ready runs back through the stages so a stall holds data.
// Synchronous reset empties the pipeline and sets the weekend mask to Friday and Saturday.
module gregorian_date_arithmetic_unit_core import gda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [4:0]  req_day,
   input  logic [3:0]  req_month,
   input  logic [13:0] req_year,
   input  logic [13:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_res_day,
   output logic [3:0]  rsp_res_month,
   output logic [13:0] rsp_res_year,
   output logic        rsp_input_valid,
   output logic        rsp_range_error,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year,
   output logic [4:0]  rsp_days_to_month_end,
   output logic [8:0]  rsp_days_to_year_end,
   output logic        rsp_is_leap,
   output logic        rsp_is_month_end,
   output logic        rsp_is_weekend,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   logic [6:0] weekend_mask_ff;
   logic [6:0] weekend_mask_in;
   req_type    req;
   step_type   s1_data;
   clamp_type  s2_data;
   sum_type    s3_data;
   rsp_type    rsp;
   logic       s1_valid, s1_ready;
   logic       s2_valid, s2_ready;
   logic       s3_valid, s3_ready;

   assign weekend_mask_in = csr_wr_en ? csr_wr_data : weekend_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weekend_mask_ff <= WEEKEND_MASK_RESET;
      end else begin
         weekend_mask_ff <= weekend_mask_in;
      end
   end

   assign req.kind   = req_kind;
   assign req.day    = req_day;
   assign req.month  = req_month;
   assign req.year   = req_year;
   assign req.amount = req_amount;

   gda_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   gda_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   gda_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   gda_facts u_facts (
      .clock        (clock),
      .reset        (reset),
      .weekend_mask (weekend_mask_ff),
      .in_valid     (s3_valid),
      .in_ready     (s3_ready),
      .in_data      (s3_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (rsp)
   );

   assign rsp_res_day           = rsp.res_day;
   assign rsp_res_month         = rsp.res_month;
   assign rsp_res_year          = rsp.res_year;
   assign rsp_input_valid       = rsp.input_valid;
   assign rsp_range_error       = rsp.range_error;
   assign rsp_weekday           = rsp.weekday;
   assign rsp_day_of_year       = rsp.day_of_year;
   assign rsp_days_to_month_end = rsp.days_to_month_end;
   assign rsp_days_to_year_end  = rsp.days_to_year_end;
   assign rsp_is_leap           = rsp.is_leap;
   assign rsp_is_month_end      = rsp.is_month_end;
   assign rsp_is_weekend        = rsp.is_weekend;

endmodule

>>> sv/gda_step.sv
// Stage 1: check the input date and apply the day, month or year step.
// Depends on gda_pkg.
module gda_step import gda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output step_type out_data
);

   logic     valid_ff;
   step_type data_ff;
   step_type data_in;
   logic     leap0;
   logic [4:0] len0;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      leap0 = leap_year(in_data.year);
      len0  = month_days(in_data.month, leap0);
      data_in.ok = (in_data.month >= MONTH_JAN) && (in_data.month <= MONTH_DEC) &&
                   (in_data.year <= YEAR_MAX) && (in_data.day != 5'd0) &&
                   (in_data.day <= len0);
      data_in.day   = in_data.day;
      data_in.month = in_data.month;
      data_in.year  = $signed({2'b00, in_data.year});
      if (data_in.ok) begin
         unique case (in_data.kind)
            KIND_NEXT_DAY: begin
               if (in_data.day == len0) begin
                  data_in.day = 5'd1;
                  if (in_data.month == MONTH_DEC) begin
                     data_in.month = MONTH_JAN;
                     data_in.year  = data_in.year + 16'sd1;
                  end else begin
                     data_in.month = in_data.month + 4'd1;
                  end
               end else begin
                  data_in.day = in_data.day + 5'd1;
               end
            end
            KIND_PREV_DAY: begin
               if (in_data.day == 5'd1) begin
                  if (in_data.month == MONTH_JAN) begin
                     data_in.month = MONTH_DEC;
                     data_in.day   = 5'd31;
                     data_in.year  = data_in.year - 16'sd1;
                  end else begin
                     data_in.month = in_data.month - 4'd1;
                     data_in.day   = month_days(in_data.month - 4'd1, leap0);
                  end
               end else begin
                  data_in.day = in_data.day - 5'd1;
               end
            end
            KIND_NEXT_MONTH: begin
               if (in_data.month == MONTH_DEC) begin
                  data_in.month = MONTH_JAN;
                  data_in.year  = data_in.year + 16'sd1;
               end else begin
                  data_in.month = in_data.month + 4'd1;
               end
            end
            KIND_PREV_MONTH: begin
               if (in_data.month == MONTH_JAN) begin
                  data_in.month = MONTH_DEC;
                  data_in.year  = data_in.year - 16'sd1;
               end else begin
                  data_in.month = in_data.month - 4'd1;
               end
            end
            KIND_ADD_YEARS: data_in.year = data_in.year + $signed({2'b00, in_data.amount});
            KIND_SUB_YEARS: data_in.year = data_in.year - $signed({2'b00, in_data.amount});
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> sv/gda_clamp.sv
// Stage 2: saturate the year, find its leap status and clamp the day.
// Depends on gda_pkg.
module gda_clamp import gda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  step_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output clamp_type out_data
);

   logic      valid_ff;
   clamp_type data_ff;
   clamp_type data_in;
   logic      over;
   logic      leap_r;
   logic [4:0] len_r;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      over = !in_data.year[15] && (in_data.year[14:0] > {1'b0, YEAR_MAX});
      data_in.ok    = in_data.ok;
      data_in.month = in_data.month;
      data_in.year  = in_data.year[13:0];
      data_in.range_err = 1'b0;
      if (in_data.ok) begin
         if (over) begin
            data_in.year      = YEAR_MAX;
            data_in.range_err = 1'b1;
         end else if (in_data.year[15]) begin
            data_in.year      = 14'd0;
            data_in.range_err = 1'b1;
         end
      end
      leap_r       = leap_year(data_in.year);
      len_r        = month_days(in_data.month, leap_r);
      data_in.leap = in_data.ok && leap_r;
      data_in.len  = len_r;
      data_in.day  = (in_data.ok && (in_data.day > len_r)) ? len_r : in_data.day;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> sv/gda_sum.sv
// Stage 3: day of year and the weekday sum before its reduction mod 7.
// Depends on gda_pkg.
module gda_sum import gda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  clamp_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output sum_type   out_data
);

   logic        valid_ff;
   sum_type     data_ff;
   sum_type     data_in;
   logic        early;
   logic [13:0] yy;
   logic [3:0]  mm;
   logic [11:0] q4;
   logic [9:0]  q100;
   logic [7:0]  q400;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      early = (in_data.month <= MONTH_FEB);
      yy    = in_data.year + WEEKDAY_YEAR_SHIFT - 14'(early);
      mm    = early ? (in_data.month + 4'd10) : (in_data.month - 4'd2);
      q4    = yy[13:2];
      q100  = div25({2'b00, q4});
      q400  = q100[9:2];
      data_in.date = in_data;
      data_in.doy  = days_before(in_data.month) + 9'(in_data.day) +
                     9'(in_data.leap && (in_data.month > MONTH_FEB));
      data_in.wsum = 15'(in_data.day) + 15'(yy) + 15'(q4) - 15'(q100) + 15'(q400) +
                     15'(month_offset(mm));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> sv/gda_facts.sv
// Stage 4: weekday, weekend flag and remaining-day counts; drives the result.
// Depends on gda_pkg.
module gda_facts import gda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] weekend_mask,
   input  logic       in_valid,
   output logic       in_ready,
   input  sum_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data
);

   logic       valid_ff;
   rsp_type    data_ff;
   rsp_type    data_in;
   logic [2:0] wd;
   logic       ok;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ok = in_data.date.ok;
      wd = ok ? mod7(in_data.wsum) : 3'd0;
      data_in.res_day     = in_data.date.day;
      data_in.res_month   = in_data.date.month;
      data_in.res_year    = in_data.date.year;
      data_in.input_valid = ok;
      data_in.range_error = ok && in_data.date.range_err;
      data_in.weekday     = wd;
      data_in.is_leap     = ok && in_data.date.leap;
      data_in.day_of_year = ok ? in_data.doy : 9'd0;
      data_in.days_to_month_end = ok ? (in_data.date.len - in_data.date.day) : 5'd0;
      data_in.days_to_year_end  =
         ok ? ((in_data.date.leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR) - in_data.doy) : 9'd0;
      data_in.is_month_end = ok && (in_data.date.day == in_data.date.len);
      data_in.is_weekend   = ok && weekend_mask[wd];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
